FILE: src/rsss_pkg.sv
package rsss_pkg;

  localparam int DIGITS      = 4;
  localparam int DIGIT_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int NUM_W       = 16;
  localparam int RADIX_W     = 5;
  localparam int CODE_W      = 5;
  localparam int SEL_W       = 4;
  localparam int SEG_W       = 8;
  localparam int BIT_CNT_W   = $clog2(NUM_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;
  localparam logic [CODE_W-1:0]  BLANK_CODE = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic                   load;       // latch number and radix, clear remainder
    logic                   div_step;   // one restoring-division bit
    logic                   store;      // write remainder to digit_idx
    logic [DIGIT_IDX_W-1:0] digit_idx;
    logic                   tick;       // present current digit, advance pointer
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;   // output register holds a result that is not being taken
  } dp_status_t;

  // active-high segment pattern, bit0 = a .. bit6 = g, bit7 = dp
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      5'd0:    seg = 8'h3F;
      5'd1:    seg = 8'h06;
      5'd2:    seg = 8'h5B;
      5'd3:    seg = 8'h4F;
      5'd4:    seg = 8'h66;
      5'd5:    seg = 8'h6D;
      5'd6:    seg = 8'h7D;
      5'd7:    seg = 8'h07;
      5'd8:    seg = 8'h7F;
      5'd9:    seg = 8'h6F;
      5'd10:   seg = 8'h77;
      5'd11:   seg = 8'h7C;
      5'd12:   seg = 8'h58;
      5'd13:   seg = 8'h5E;
      5'd14:   seg = 8'h79;
      5'd15:   seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: src/rsss_ctrl.sv
module rsss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  input  rsss_pkg::dp_status_t status,
  output rsss_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_STORE  = 3'b100
  } state_t;

  state_t                           state, state_next;
  logic [rsss_pkg::BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  logic [rsss_pkg::DIGIT_IDX_W-1:0] digit_idx, digit_idx_next;
  logic                             accept;

  assign s_tready = (state == ST_IDLE) && !status.out_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    digit_idx_next = digit_idx;
    cmd            = '0;
    cmd.digit_idx  = digit_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == rsss_pkg::OP_TICK) begin
            cmd.tick = 1'b1;
          end else begin
            cmd.load       = 1'b1;
            bit_cnt_next   = '0;
            digit_idx_next = '0;
            state_next     = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == rsss_pkg::BIT_CNT_W'(rsss_pkg::NUM_W - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (digit_idx == rsss_pkg::DIGIT_IDX_W'(rsss_pkg::DIGITS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          digit_idx_next = digit_idx + 1'b1;
          bit_cnt_next   = '0;
          state_next     = ST_DIVIDE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      digit_idx <= '0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      digit_idx <= digit_idx_next;
    end
  end

endmodule

FILE: src/rsss_dp.sv
module rsss_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rsss_pkg::NUM_W-1:0]       number,
  input  logic [rsss_pkg::RADIX_W-1:0]     radix,
  input  rsss_pkg::ctrl_cmd_t              cmd,
  output rsss_pkg::dp_status_t             status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rsss_pkg::SEL_W-1:0]       digit_select_n,
  output logic [rsss_pkg::SEG_W-1:0]       segments_n
);

  logic [rsss_pkg::NUM_W-1:0]       value;
  logic [rsss_pkg::RADIX_W-1:0]     base;
  logic [rsss_pkg::RADIX_W-1:0]     rem;
  logic [rsss_pkg::CODE_W-1:0]      digit_store [rsss_pkg::DIGITS];
  logic [rsss_pkg::DIGIT_IDX_W-1:0] scan_pointer;

  logic [rsss_pkg::RADIX_W-1:0]     base_clamped;
  logic [rsss_pkg::RADIX_W-1:0]     rem_shift;
  logic                             q_bit;
  logic [rsss_pkg::CODE_W-1:0]      code;
  logic [rsss_pkg::SEL_W-1:0]       sel_n;

  always_comb begin
    if (radix < rsss_pkg::RADIX_MIN) begin
      base_clamped = rsss_pkg::RADIX_MIN;
    end else if (radix > rsss_pkg::RADIX_MAX) begin
      base_clamped = rsss_pkg::RADIX_MAX;
    end else begin
      base_clamped = radix;
    end
  end

  // restoring division, one quotient bit per step; rem < base <= 16 so 5 bits hold the shift
  assign rem_shift = {rem[rsss_pkg::RADIX_W-2:0], value[rsss_pkg::NUM_W-1]};
  assign q_bit     = (rem_shift >= base);

  always_comb begin
    code = digit_store[scan_pointer];
    if (code > rsss_pkg::BLANK_CODE) begin
      code = rsss_pkg::BLANK_CODE;
    end
    sel_n = '1;
    if (32'(scan_pointer) < rsss_pkg::SEL_W) begin
      sel_n[scan_pointer] = 1'b0;
    end
  end

  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= number;
      base  <= base_clamped;
      rem   <= '0;
    end else if (cmd.div_step) begin
      value <= {value[rsss_pkg::NUM_W-2:0], q_bit};
      rem   <= q_bit ? (rem_shift - base) : rem_shift;
    end else if (cmd.store) begin
      rem <= '0;
    end
    if (cmd.tick) begin
      digit_select_n <= sel_n;
      segments_n     <= ~rsss_pkg::seg_lookup(code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rsss_pkg::DIGITS; i++) begin
        digit_store[i] <= rsss_pkg::BLANK_CODE;
      end
      scan_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.store) begin
        digit_store[cmd.digit_idx] <= {1'b0, rem[rsss_pkg::CODE_W-2:0]};
      end
      if (cmd.tick) begin
        if (scan_pointer == rsss_pkg::DIGIT_IDX_W'(rsss_pkg::DIGITS - 1)) begin
          scan_pointer <= '0;
        end else begin
          scan_pointer <= scan_pointer + 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/radix_seven_segment_scanner_core.sv
// Multiplexed four-digit seven-segment driver with a selectable radix.
//
// Input stream (s_*): s_tuser is the operation (0 = load, 1 = scan tick).
// A load transaction carries the number and radix in s_tdata; it splits the
// number into its four lowest digits (radix clamped to 2..16) and produces
// no output. A tick transaction returns one output transaction with the
// active-low digit select and active-low segment pattern of the digit under
// the scan pointer, then advances the pointer modulo four.
//
// Timing: a tick's result is in the output register on the next cycle after
// the tick is taken. A load runs a bit-serial restoring divider, 16 division
// steps plus one store step per digit, so the block stays busy after the load
// transaction until the last digit is stored; the
// input is not ready meanwhile. Back-to-back ticks run at one per cycle
// while the receiver keeps m_tready high.
//
// Reset: all digits read blank (all segments off), scan pointer at digit 0.
// Output stall: the result holds in the output register; on the output side a
// new transaction is refused only while that register is full and not being drained.
module radix_seven_segment_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] number, [20:16] radix, [23:21] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [3:0] digit_select_n, [11:4] segments_n, [15:12] zero
);

  rsss_pkg::ctrl_cmd_t          cmd;
  rsss_pkg::dp_status_t         status;
  logic [rsss_pkg::SEL_W-1:0]   digit_select_n;
  logic [rsss_pkg::SEG_W-1:0]   segments_n;

  // FSM: idle / divide / store per digit
  rsss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // divider, digit store, scan pointer and output register
  rsss_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .number         (s_tdata[15:0]),
    .radix          (s_tdata[20:16]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .digit_select_n (digit_select_n),
    .segments_n     (segments_n)
  );

  assign m_tdata = {4'b0000, segments_n, digit_select_n};

endmodule

FILE: dv/tb_radix_seven_segment_scanner_core.sv
module tb_radix_seven_segment_scanner_core;
  import rsss_pkg::*;

  localparam int STALL_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 100;  // outlasts the time a load keeps the block busy

  // Segment patterns, active high, bit0 = a .. bit6 = g; entry 16 is blank.
  localparam logic [7:0] GLYPH [17] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71,
    8'h00
  };

  typedef enum logic [1:0] {CHK_NONE, CHK_MODEL, CHK_TYPED} chk_e;

  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] seg;
  } frame_t;

  typedef struct packed {
    logic        op;
    logic [15:0] num;
    logic [4:0]  rad;
    chk_e        chk;
    logic [3:0]  sel;
    logic [7:0]  seg;
  } row_t;

  // Directed sequence. Typed rows are read straight off the digit contents.
  localparam int N_DIRECTED = 25;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // blank digits out of reset
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'hE, 8'hFF},
    '{OP_TICK, 16'hFFFF, 5'd31, CHK_TYPED, 4'hD, 8'hFF},
    // all-F load; pointer stays at digit 2
    '{OP_LOAD, 16'hFFFF, 5'd16, CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'hB, 8'h8E},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'h7, 8'h8E},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'hE, 8'h8E},
    // zero overwrites every digit with a leading zero
    '{OP_LOAD, 16'h0000, 5'd2,  CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'hD, 8'hC0},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_TYPED, 4'hB, 8'hC0},
    // radix clamping at both ends
    '{OP_LOAD, 16'hFFFF, 5'd0,  CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_LOAD, 16'hFFFF, 5'd1,  CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_LOAD, 16'hFFFF, 5'd31, CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    // decimal with a dropped fifth digit, then a radix above 16
    '{OP_LOAD, 16'd12345, 5'd10, CHK_NONE, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_LOAD, 16'hABCD, 5'd17, CHK_NONE,  4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00},
    '{OP_TICK, 16'h0000, 5'd0,  CHK_MODEL, 4'h0, 8'h00}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] number, [20:16] radix, [23:21] zero
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [3:0] digit_select_n, [11:4] segments_n, [15:12] zero

  // predictor state
  logic [4:0]  digit_model [DIGITS];
  logic [1:0]  pointer_model;
  frame_t      pending_frames [$];

  int          errors;
  int          n_loads;
  int          n_ticks;
  int          n_checked;
  logic        calm;      // no idling on either side while set

  radix_seven_segment_scanner_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Load: split into the lowest digits with a clamped radix, no frame.
  // Tick: frame for the digit under the pointer, then advance.
  task automatic scan_model(input logic op, input logic [15:0] num, input logic [4:0] rad,
                            output logic shows, output frame_t fr);
    int base;
    int value;
    fr = '0;
    shows = 1'b0;
    if (op == OP_LOAD) begin
      base = (rad < RADIX_MIN) ? int'(RADIX_MIN) : (rad > RADIX_MAX) ? int'(RADIX_MAX) : rad;
      value = num;
      for (int i = 0; i < DIGITS; i++) begin
        digit_model[i] = 5'(value % base);
        value = value / base;
      end
    end else begin
      fr.sel = ~(4'b0001 << pointer_model);
      fr.seg = ~GLYPH[digit_model[pointer_model]];
      pointer_model = pointer_model + 2'd1;
      shows = 1'b1;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input row_t row);
    logic   shows;
    frame_t fr;
    while (!calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= {3'b000, row.rad, row.num};
    do @(posedge clk); while (!s_tready);
    scan_model(row.op, row.num, row.rad, shows, fr);
    if (row.op == OP_LOAD) n_loads++;
    else n_ticks++;
    if (shows) begin
      if (row.chk == CHK_TYPED) pending_frames.push_back({row.sel, row.seg});
      else pending_frames.push_back(fr);
    end
    @(negedge clk);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= (!calm && $urandom_range(99) < 33) ? 1'b0 : 1'b1;
  end

  // Output checker: every frame against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, expected none, got %h", $time, m_tdata);
      end else begin
        if (m_tdata[3:0] !== pending_frames[0].sel) begin
          errors++;
          $display("%0t: digit_select_n mismatch, expected %h, got %h",
                   $time, pending_frames[0].sel, m_tdata[3:0]);
        end
        if (m_tdata[11:4] !== pending_frames[0].seg) begin
          errors++;
          $display("%0t: segments_n mismatch, expected %h, got %h",
                   $time, pending_frames[0].seg, m_tdata[11:4]);
        end
        void'(pending_frames.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog on cycles with no transaction at all.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("tb_radix_seven_segment_scanner_core failed");
    $finish;
  end

  initial begin
    row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_LOAD;
    m_tready = 1'b0;
    calm = 1'b0;
    errors = 0;
    n_loads = 0;
    n_ticks = 0;
    n_checked = 0;
    for (int i = 0; i < DIGITS; i++) digit_model[i] = BLANK_CODE;
    pointer_model = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) send_item(DIRECTED[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 150 && i < 300);
      row.op  = ($urandom_range(3) == 0) ? OP_LOAD : OP_TICK;
      case ($urandom_range(7))
        0:       row.num = 16'h0000;
        1:       row.num = 16'hFFFF;
        2:       row.num = 16'($urandom_range(255));
        default: row.num = 16'($urandom);
      endcase
      // mostly legal radices, some outside 2..16 to hit clamping
      row.rad = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2));
      row.chk = CHK_MODEL;
      row.sel = '0;
      row.seg = '0;
      send_item(row);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d loads and %0d scan ticks, %0d display frames checked",
             n_loads, n_ticks, n_checked);
    $display("covered blank digits, radix clamping, all radices and random back-pressure");
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("tb_radix_seven_segment_scanner_core passed");
    end else begin
      $display("tb_radix_seven_segment_scanner_core failed");
    end
    $finish;
  end

endmodule
